// ----- src/dsd_pkg.sv -----
// Shared types and constants of the event stream deframer.
// Used by the front parser, the item queue, the value back end and the top level.
`default_nettype none
package dsd_pkg;

    localparam int CHANNELS_PER_CHIP = 128;
    localparam int CHIP_HEADER_WORDS = 16;
    localparam int CHIP_COUNT        = 2;

    localparam int QUEUE_DEPTH = 4;

    // result kinds
    localparam logic [3:0] KIND_TYPE   = 4'd0;
    localparam logic [3:0] KIND_SIZE   = 4'd1;
    localparam logic [3:0] KIND_CHARGE = 4'd2;
    localparam logic [3:0] KIND_DELAY  = 4'd3;
    localparam logic [3:0] KIND_CLOCK  = 4'd4;
    localparam logic [3:0] KIND_TIME   = 4'd5;
    localparam logic [3:0] KIND_TEMP   = 4'd6;
    localparam logic [3:0] KIND_HDR    = 4'd7;
    localparam logic [3:0] KIND_SAMPLE = 4'd8;
    localparam logic [3:0] KIND_USRERR = 4'd9;
    localparam logic [3:0] KIND_STOP   = 4'd10;

    // configuration register indexes
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_FIRST  = 2'd1;
    localparam logic [1:0] REG_STOP   = 2'd2;

    typedef struct packed {
        logic [1:0]  format_version;
        logic [30:0] first_event;
        logic [30:0] stop_event;
    } cfg_t;

    // classified item passed from the parser to the back end
    typedef struct packed {
        logic [3:0]  kind;
        logic [31:0] raw;
        logic        chip;
        logic [7:0]  position;
        logic [30:0] event_number;
        logic        last;
    } item_t;

endpackage
`default_nettype wire

// ----- src/dsd_front.sv -----
// Byte assembler and field parser: gathers words, tracks the event layout
// and emits one classified item per decoded field. Depends on dsd_pkg.
`default_nettype none
module dsd_front import dsd_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       byte_valid,
    input  wire logic [7:0] byte_data,
    output logic            item_valid,
    output item_t           item
);

    localparam logic [3:0] PH_HUNT  = 4'd0;
    localparam logic [3:0] PH_SIZE  = 4'd1;
    localparam logic [3:0] PH_CAL   = 4'd2;
    localparam logic [3:0] PH_CLK_D = 4'd3;
    localparam logic [3:0] PH_CLK   = 4'd4;
    localparam logic [3:0] PH_TIM_D = 4'd5;
    localparam logic [3:0] PH_TIM   = 4'd6;
    localparam logic [3:0] PH_TEMP  = 4'd7;
    localparam logic [3:0] PH_HDR   = 4'd8;
    localparam logic [3:0] PH_SAMP  = 4'd9;

    // double to signed 32 bits, truncated toward zero, saturating
    function automatic logic [31:0] dbl_to_i32(input logic [63:0] bits);
        logic        neg;
        logic [10:0] e;
        logic [51:0] m;
        logic [10:0] ex;
        logic [52:0] sh;
        logic [31:0] mag;
        neg = bits[63];
        e   = bits[62:52];
        m   = bits[51:0];
        ex  = e - 11'd1023;
        sh  = {1'b1, m} >> (6'd52 - ex[5:0]);
        mag = sh[31:0];
        if (e == 11'h7FF && m != 52'd0) begin
            dbl_to_i32 = 32'd0;
        end else if (e < 11'd1023) begin
            dbl_to_i32 = 32'd0;
        end else if (ex >= 11'd31) begin
            dbl_to_i32 = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            dbl_to_i32 = neg ? (32'd0 - mag) : mag;
        end
    endfunction

    logic [3:0]  phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic [63:0] asm_reg, asm_next;
    logic        chip_reg, chip_next;
    logic [7:0]  word_reg, word_next;
    logic [30:0] count_reg, count_next;
    logic        en_reg, en_next;
    logic        halt_reg, halt_next;
    logic        iv_reg, iv_next;
    item_t       item_reg, item_next;

    logic [63:0] asm_c;
    logic [3:0]  ph;
    logic [2:0]  flen;
    logic [31:0] w;
    logic [31:0] v;
    logic [8:0]  nxt;
    logic        chip_end, ev_end;

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        asm_next   = asm_reg;
        chip_next  = chip_reg;
        word_next  = word_reg;
        count_next = count_reg;
        en_next    = en_reg;
        halt_next  = halt_reg;
        iv_next    = 1'b0;
        item_next  = item_reg;
        asm_c      = asm_reg | (64'(byte_data) << {pos_reg, 3'b000});
        ph         = (phase_reg > PH_SAMP) ? PH_HUNT : phase_reg;
        w          = asm_c[31:0];
        v          = dbl_to_i32(asm_c);
        nxt        = 9'(word_reg) + 9'd1;
        chip_end   = nxt >= 9'(CHANNELS_PER_CHIP);
        ev_end     = chip_end && (32'(chip_reg) + 32'd1 >= 32'(CHIP_COUNT));
        flen       = 3'd4;
        if (byte_valid && !halt_reg) begin
            item_next.chip         = 1'b0;
            item_next.position     = 8'd0;
            item_next.last         = 1'b0;
            item_next.raw          = 32'd0;
            item_next.kind         = KIND_STOP;
            item_next.event_number = count_reg;
            // delay goes out on the byte after the calibration double
            if (ph == PH_CLK_D || ph == PH_TIM_D) begin
                iv_next        = en_reg;
                item_next.kind = KIND_DELAY;
                item_next.raw  = {16'd0, asm_c[63:48]};
                ph             = ph + 4'd1;
            end
            case (ph)
                PH_CAL:                   flen = 3'd0;
                PH_TEMP, PH_HDR, PH_SAMP: flen = 3'd2;
                default:                  flen = 3'd4;
            endcase
            phase_next = ph;
            if (flen != 3'd0 && 4'(pos_reg) + 4'd1 < 4'(flen)) begin
                pos_next = pos_reg + 3'd1;
                asm_next = asm_c;
            end else if (flen == 3'd0 && pos_reg != 3'd7) begin
                pos_next = pos_reg + 3'd1;
                asm_next = asm_c;
            end else begin
                pos_next = 3'd0;
                asm_next = 64'd0;
                case (ph)
                    PH_HUNT: begin
                        if (w[31:16] == 16'hCAFE) begin
                            count_next = (count_reg != 31'h7FFF_FFFF) ?
                                         count_reg + 31'd1 : count_reg;
                            item_next.event_number = count_next;
                            item_next.raw = {20'd0, w[11:0]};
                            if (w[12]) begin
                                halt_next      = 1'b1;
                                iv_next        = 1'b1;
                                item_next.kind = KIND_USRERR;
                                item_next.last = 1'b1;
                            end else if (cfg.stop_event != 31'd0 &&
                                         count_next >= cfg.stop_event) begin
                                halt_next      = 1'b1;
                                iv_next        = 1'b1;
                                item_next.kind = KIND_STOP;
                                item_next.raw  = 32'd0;
                                item_next.last = 1'b1;
                            end else begin
                                en_next        = count_next >= cfg.first_event;
                                phase_next     = PH_SIZE;
                                iv_next        = en_next;
                                item_next.kind = KIND_TYPE;
                            end
                        end
                    end
                    PH_SIZE: begin
                        phase_next     = PH_CAL;
                        iv_next        = en_reg;
                        item_next.kind = KIND_SIZE;
                        item_next.raw  = w;
                    end
                    PH_CAL: begin
                        asm_next       = {v, 32'd0};
                        phase_next     = (cfg.format_version == 2'd3) ? PH_CLK_D : PH_TIM_D;
                        iv_next        = en_reg;
                        item_next.kind = KIND_CHARGE;
                        item_next.raw  = {24'd0, v[7:0]};
                    end
                    PH_CLK: begin
                        phase_next     = PH_TIM;
                        iv_next        = en_reg;
                        item_next.kind = KIND_CLOCK;
                        item_next.raw  = w;
                    end
                    PH_TIM: begin
                        phase_next     = PH_TEMP;
                        iv_next        = en_reg;
                        item_next.kind = KIND_TIME;
                        item_next.raw  = w;
                    end
                    PH_TEMP: begin
                        phase_next     = PH_HDR;
                        chip_next      = 1'b0;
                        word_next      = 8'd0;
                        iv_next        = en_reg;
                        item_next.kind = KIND_TEMP;
                        item_next.raw  = {16'd0, w[15:0]};
                    end
                    PH_HDR: begin
                        iv_next            = en_reg;
                        item_next.kind     = KIND_HDR;
                        item_next.raw      = {16'd0, w[15:0]};
                        item_next.chip     = chip_reg;
                        item_next.position = word_reg;
                        if (nxt >= 9'(CHIP_HEADER_WORDS)) begin
                            word_next  = 8'd0;
                            phase_next = PH_SAMP;
                        end else begin
                            word_next = nxt[7:0];
                        end
                    end
                    PH_SAMP: begin
                        iv_next            = en_reg;
                        item_next.kind     = KIND_SAMPLE;
                        item_next.raw      = {16'd0, w[15:0]};
                        item_next.chip     = chip_reg;
                        item_next.position = word_reg;
                        item_next.last     = ev_end;
                        if (!chip_end) begin
                            word_next = nxt[7:0];
                        end else begin
                            word_next = 8'd0;
                            if (ev_end) begin
                                chip_next  = 1'b0;
                                phase_next = PH_HUNT;
                            end else begin
                                chip_next  = ~chip_reg;
                                phase_next = PH_HDR;
                            end
                        end
                    end
                    default: begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            pos_reg   <= 3'd0;
            asm_reg   <= 64'd0;
            chip_reg  <= 1'b0;
            word_reg  <= 8'd0;
            count_reg <= 31'd0;
            en_reg    <= 1'b0;
            halt_reg  <= 1'b0;
            iv_reg    <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            asm_reg   <= asm_next;
            chip_reg  <= chip_next;
            word_reg  <= word_next;
            count_reg <= count_next;
            en_reg    <= en_next;
            halt_reg  <= halt_next;
            iv_reg    <= iv_next;
        end
        item_reg <= item_next;
    end

    assign item_valid = iv_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

// ----- src/dsd_fifo.sv -----
// Short item queue between the parser and the back end.
// Depends on dsd_pkg for the item type and depth.
`default_nettype none
module dsd_fifo import dsd_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       ready_in,
    input  wire logic  pop,
    output logic       not_empty,
    output item_t      head
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    item_t         mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          do_push, do_pop;

    // room is kept for the item the parser may have in flight
    assign ready_in  = cnt_reg < (AW + 1)'(QUEUE_DEPTH - 1);
    assign not_empty = cnt_reg != '0;
    assign do_push   = push;
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) wp_reg <= wp_reg + AW'(1);
            if (do_pop)  rp_reg <= rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
        end
        if (do_push) mem_reg[wp_reg] <= push_item;
    end

    ovf_chk: assert property (@(posedge aclk) disable iff (!aresetn)
        !(do_push && !do_pop && cnt_reg == (AW + 1)'(QUEUE_DEPTH)))
        else $error("item queue overflow");
    cnt_chk: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + (AW + 1)'(1))
        else $error("queue count did not advance on push");
    emp_chk: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wp_reg == rp_reg))
        else $error("empty queue with unequal pointers");

endmodule
`default_nettype wire

// ----- src/dsd_back.sv -----
// Value back end: three stage pipeline turning classified items into results
// (fixed point time and temperature). Depends on dsd_pkg.
`default_nettype none
module dsd_back import dsd_pkg::*; (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire item_t         in_item,
    output logic               in_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [3:0]         out_kind,
    output logic signed [40:0] out_value,
    output logic               out_chip,
    output logic [7:0]         out_position,
    output logic [30:0]        out_event_number,
    output logic               out_last
);

    logic               adv;
    logic               v1_reg, v2_reg, v3_reg;
    item_t              it1_reg, it2_reg;
    logic [31:0]        tnum1_reg;
    logic signed [31:0] tint1_reg, tint2_reg;
    logic [31:0]        pnum1_reg;
    logic               pzero1_reg, pzero2_reg;
    logic [15:0]        tq2_reg;
    logic [21:0]        pq2_reg;
    logic [15:0]        fneg;
    logic [63:0]        tprod, pprod;
    logic signed [40:0] val;
    item_t              it3_reg;
    logic signed [40:0] val3_reg;

    assign adv    = !v3_reg || out_ready;
    assign in_pop = adv;
    assign fneg   = in_item.raw[31] ? (16'd0 - in_item.raw[15:0]) : in_item.raw[15:0];
    assign tprod  = 64'(tnum1_reg) * 64'h0000_0000_8000_8001;
    assign pprod  = 64'(pnum1_reg) * 64'd1374389535;

    always_comb begin
        case (it2_reg.kind)
            KIND_TYPE, KIND_USRERR: val = 41'(it2_reg.raw[11:0]);
            KIND_SIZE, KIND_CLOCK:  val = 41'(it2_reg.raw);
            KIND_CHARGE:            val = 41'({it2_reg.raw[7:0], 10'd0});
            KIND_DELAY, KIND_SAMPLE: val = 41'($signed(it2_reg.raw[15:0]));
            KIND_TIME:              val = 41'(tint2_reg) + 41'(tq2_reg);
            KIND_TEMP:              val = pzero2_reg ? 41'(9999 * 256) :
                                          41'(pq2_reg) - 41'd10189;
            KIND_HDR:               val = 41'(it2_reg.raw[15:0]);
            default:                val = 41'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        if (adv) begin
            // stage 1: scale the fraction and temperature code
            it1_reg    <= in_item;
            tnum1_reg  <= 32'(fneg) * 32'd25600 + 32'd32767;
            tint1_reg  <= 32'($signed(in_item.raw[31:16])) * 32'sd25600;
            pnum1_reg  <= 32'(in_item.raw[15:0]) * 32'd3072 + 32'd70;
            pzero1_reg <= in_item.raw[15:0] == 16'd0;
            // stage 2: divide by 65535 and by 100 through reciprocals
            it2_reg    <= it1_reg;
            tint2_reg  <= tint1_reg;
            tq2_reg    <= tprod[62:47];
            pq2_reg    <= pprod[58:37];
            pzero2_reg <= pzero1_reg;
            // stage 3: result register
            it3_reg    <= it2_reg;
            val3_reg   <= val;
        end
    end

    assign out_valid        = v3_reg;
    assign out_kind         = it3_reg.kind;
    assign out_value        = val3_reg;
    assign out_chip         = it3_reg.chip;
    assign out_position     = it3_reg.position;
    assign out_event_number = it3_reg.event_number;
    assign out_last         = it3_reg.last;

    last_chk: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_last) |->
        (out_kind == KIND_SAMPLE || out_kind == KIND_USRERR || out_kind == KIND_STOP))
        else $error("last set on a non-final kind");
    chip_chk: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && (out_chip || out_position != 8'd0)) |->
        (out_kind == KIND_HDR || out_kind == KIND_SAMPLE))
        else $error("chip or position set outside a chip block");
    stall_chk: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
        else $error("result lost under stall");

endmodule
`default_nettype wire

// ----- src/detector_event_stream_deframer.sv -----
// Event stream deframer: one stream byte per beat; a result raises m_tvalid once the beat that
// yields it has passed the parser register, the queue and the three value stages.
// Throughput: one byte per cycle while s_tready is high; the queue and output pipeline stall on m_tready.
// Reset (aresetn low, synchronous) clears parse state, the queue and pipeline valids
// and restores format_version = 3, first_event = 0, stop_event = 0.
// Depends on dsd_pkg, dsd_front, dsd_fifo and dsd_back.
`default_nettype none
module detector_event_stream_deframer import dsd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] stream_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata,   // value[40:0] chip[41] position[49:42]
                                        // event_number[80:50], zero fill [87:81]
    output logic [3:0]       m_tuser,   // kind[3:0]
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    cfg_t               cfg_reg;
    logic               wr;
    logic               fv;
    item_t              fi;
    logic               q_ne;
    item_t              q_head;
    logic               q_pop;
    logic signed [40:0] o_value;
    logic               o_chip;
    logic [7:0]         o_pos;
    logic [30:0]        o_evn;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.format_version <= 2'd3;
            cfg_reg.first_event    <= 31'd0;
            cfg_reg.stop_event     <= 31'd0;
        end else if (wr) begin
            case (paddr[3:2])
                REG_FORMAT: cfg_reg.format_version <= pwdata[1:0];
                REG_FIRST:  cfg_reg.first_event    <= pwdata[30:0];
                REG_STOP:   cfg_reg.stop_event     <= pwdata[30:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FORMAT: prdata = {30'd0, cfg_reg.format_version};
            REG_FIRST:  prdata = {1'b0, cfg_reg.first_event};
            REG_STOP:   prdata = {1'b0, cfg_reg.stop_event};
            default:    prdata = 32'd0;
        endcase
    end

    dsd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .byte_valid (s_tvalid && s_tready),
        .byte_data  (s_tdata),
        .item_valid (fv),
        .item       (fi)
    );

    dsd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fv),
        .push_item (fi),
        .ready_in  (s_tready),
        .pop       (q_pop),
        .not_empty (q_ne),
        .head      (q_head)
    );

    dsd_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (q_ne),
        .in_item          (q_head),
        .in_pop           (q_pop),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_kind         (m_tuser),
        .out_value        (o_value),
        .out_chip         (o_chip),
        .out_position     (o_pos),
        .out_event_number (o_evn),
        .out_last         (m_tlast)
    );

    assign m_tdata = {7'd0, o_evn, o_pos, o_chip, o_value};

endmodule
`default_nettype wire
